### hdl/fwes_pkg.sv
package fwes_pkg;

	localparam int MAX_LENGTH_DEF = 4096;

	localparam int BYTE_W = 8;
	localparam int CAND_W = 12;
	localparam int LEN_W = 13;
	localparam int WEIGHT_W = 8;
	localparam int CNT_W = 4;

	// Map row width; one row is cleared per cycle
	localparam int ROW_BITS = 16;
	localparam int ROW_SEL_W = 4;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_WEIGHT = 1'd1;

	localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 13'd4096;
	localparam logic [WEIGHT_W-1:0] ERROR_WEIGHT_RST = 8'd1;

	typedef struct packed {
		logic clear;
		logic rd;
		logic wr;
	} map_ctrl_t;

endpackage

### hdl/fwes_mod_unit.sv
module fwes_mod_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fwes_pkg::CAND_W-1:0]     dividend,
	input  logic [fwes_pkg::LEN_W-1:0]      divisor,
	output logic                            done,
	output logic [fwes_pkg::CAND_W-1:0]     remainder
);

	logic [fwes_pkg::CAND_W-1:0] sh_q;
	logic [fwes_pkg::CAND_W-1:0] rem_q;
	logic [fwes_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [fwes_pkg::LEN_W-1:0]  trial;
	logic [fwes_pkg::LEN_W-1:0]  diff;
	logic [fwes_pkg::CAND_W-1:0] rem_next;

	// One quotient bit per cycle; remainder stays below the divisor
	assign trial = {rem_q, sh_q[fwes_pkg::CAND_W-1]};
	assign diff = trial - divisor;
	assign rem_next = (trial >= divisor) ? diff[fwes_pkg::CAND_W-1:0]
		: trial[fwes_pkg::CAND_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= fwes_pkg::CNT_W'(fwes_pkg::CAND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[fwes_pkg::CAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

### hdl/fwes_map.sv
module fwes_map #(
	parameter int ADDR_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fwes_pkg::map_ctrl_t               ctrl,
	input  logic [ADDR_W-1:0]                 addr,
	input  logic [fwes_pkg::ROW_BITS-1:0]     wdata,
	output logic [fwes_pkg::ROW_BITS-1:0]     rdata,
	output logic                              busy
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [fwes_pkg::ROW_BITS-1:0] mem [DEPTH];
	logic [fwes_pkg::ROW_BITS-1:0] rdata_q;
	logic [ADDR_W-1:0]             clr_idx_q;
	logic                          busy_q;

	// Sweep all rows after reset and on every clear request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (ctrl.clear) begin
			busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {ADDR_W{1'b1}})
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_idx_q] <= '0;
		else if (ctrl.wr)
			mem[addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign busy = busy_q;

endmodule

### hdl/fixed_weight_error_sampler_core.sv
// A byte that yields a position passes the bit-serial modulo, remainder capture,
// map read and map update, and out_valid rises with the map update. No new byte
// is taken until the state machine is back in idle; the check state holds while a
// result waits. A zero candidate returns after the modulo; other bytes stay idle.
// A byte marked first, and reset (arst_n low), clear the map one row per cycle
// with the input stalled; reset also clears control state.
module fixed_weight_error_sampler_core #(
	parameter int MAX_LENGTH = fwes_pkg::MAX_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fwes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fwes_pkg::LEN_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fwes_pkg::BYTE_W-1:0]       seed_byte,
	input  logic                              first,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fwes_pkg::CAND_W-1:0]       position,
	output logic                              last
);

	localparam int ROWS = (MAX_LENGTH + fwes_pkg::ROW_BITS - 1) / fwes_pkg::ROW_BITS;
	localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [fwes_pkg::LEN_W-1:0] MAX_LEN_L = fwes_pkg::LEN_W'(MAX_LENGTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MOD   = 4'b0010,
		ST_READ  = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

	state_t state_q;

	logic [fwes_pkg::LEN_W-1:0]    code_length_q;
	logic [fwes_pkg::WEIGHT_W-1:0] error_weight_q;
	logic [fwes_pkg::BYTE_W-1:0]   held_byte_q;
	logic                          held_valid_q;
	logic [fwes_pkg::WEIGHT_W-1:0] chosen_count_q;
	logic                          finished_q;
	logic [fwes_pkg::CAND_W-1:0]   cand_q;
	logic                          out_valid_q;
	logic [fwes_pkg::CAND_W-1:0]   position_q;
	logic                          last_q;

	logic                          in_xfer;
	logic                          mod_start;
	logic [fwes_pkg::CAND_W-1:0]   pair_val;
	logic [fwes_pkg::LEN_W-1:0]    eff_len;
	logic                          mod_done;
	logic [fwes_pkg::CAND_W-1:0]   mod_rem;
	fwes_pkg::map_ctrl_t           map_ctrl;
	logic [ADDR_W-1:0]             map_addr;
	logic [fwes_pkg::ROW_BITS-1:0] map_wdata;
	logic [fwes_pkg::ROW_BITS-1:0] map_rdata;
	logic                          map_busy;
	logic [fwes_pkg::ROW_SEL_W-1:0] bit_sel;
	logic                          bit_used;
	logic                          out_free;
	logic                          take_pos;
	logic [fwes_pkg::WEIGHT_W-1:0] count_next;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && !map_busy;
	assign in_xfer = in_valid && in_ready;

	assign pair_val = {held_byte_q[7:4], held_byte_q[3:0] ^ seed_byte[7:4], seed_byte[3:0]};
	assign eff_len = (code_length_q == '0 || code_length_q > MAX_LEN_L) ? MAX_LEN_L
		: code_length_q;
	assign mod_start = in_xfer && !first && !finished_q && held_valid_q;

	assign bit_sel = cand_q[fwes_pkg::ROW_SEL_W-1:0];
	assign bit_used = map_rdata[bit_sel];
	assign out_free = !out_valid_q || out_ready;
	assign take_pos = (state_q == ST_CHECK) && !bit_used && out_free;
	assign count_next = chosen_count_q + 1'b1;

	assign map_ctrl.clear = in_xfer && first;
	assign map_ctrl.rd = (state_q == ST_READ);
	assign map_ctrl.wr = take_pos;
	assign map_addr = ADDR_W'(cand_q[fwes_pkg::CAND_W-1:fwes_pkg::ROW_SEL_W]);
	assign map_wdata = map_rdata | (fwes_pkg::ROW_BITS'(1) << bit_sel);

	fwes_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (pair_val),
		.divisor   (eff_len),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	fwes_map #(
		.ADDR_W (ADDR_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (map_ctrl),
		.addr   (map_addr),
		.wdata  (map_wdata),
		.rdata  (map_rdata),
		.busy   (map_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= fwes_pkg::CODE_LENGTH_RST;
			error_weight_q <= fwes_pkg::ERROR_WEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fwes_pkg::REG_CODE_LENGTH:  code_length_q <= cfg_data;
				fwes_pkg::REG_ERROR_WEIGHT: error_weight_q <= cfg_data[fwes_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_valid_q <= 1'b0;
			chosen_count_q <= '0;
			finished_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !take_pos)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (first) begin
							held_valid_q <= 1'b1;
							chosen_count_q <= '0;
							finished_q <= 1'b0;
						end else if (!finished_q) begin
							held_valid_q <= 1'b1;
							if (held_valid_q)
								state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					// drop position zero without touching the map
					if (mod_done)
						state_q <= (mod_rem == '0) ? ST_IDLE : ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (bit_used) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						chosen_count_q <= count_next;
						if (count_next == error_weight_q)
							finished_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (first || (!finished_q)))
			held_byte_q <= seed_byte;
		if (state_q == ST_MOD && mod_done)
			cand_q <= mod_rem;
		if (take_pos) begin
			position_q <= cand_q;
			last_q <= (count_next == error_weight_q);
		end
	end

	assign out_valid = out_valid_q;
	assign position = position_q;
	assign last = last_q;

endmodule

### tb/tb_fixed_weight_error_sampler_core.sv
`timescale 1ns / 100ps

module tb_fixed_weight_error_sampler_core;

	localparam int DEPTH = fwes_pkg::MAX_LENGTH_DEF;
	localparam int ITEMS = 1150;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [fwes_pkg::CAND_W-1:0] position;
		logic last;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fwes_pkg::CFG_IDX_W-1:0] cfg_index = fwes_pkg::REG_CODE_LENGTH;
	logic [fwes_pkg::LEN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [fwes_pkg::BYTE_W-1:0] seed_byte = '0;
	logic first = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [fwes_pkg::CAND_W-1:0] position;
	logic last;

	// sampler state as seen from outside
	logic [fwes_pkg::LEN_W-1:0] len_reg = fwes_pkg::CODE_LENGTH_RST;
	logic [fwes_pkg::WEIGHT_W-1:0] weight_reg = fwes_pkg::ERROR_WEIGHT_RST;
	logic [fwes_pkg::BYTE_W-1:0] prev_byte = '0;
	bit prev_ok;
	logic [fwes_pkg::WEIGHT_W-1:0] pick_count = '0;
	bit vec_done;
	bit taken [DEPTH];

	pick_t pending_picks [$];
	pick_t oldest_pick;
	int mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycles = 0;
	logic steady = 1'b0;
	int unsigned hold_seq = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	fixed_weight_error_sampler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.seed_byte(seed_byte),
		.first(first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.last(last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, a long hold-off on request, or always ready when steady
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 21);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_picks.size() == 0) begin
				$error("unexpected result: position %0d last %0b", position, last);
				mismatches++;
			end else begin
				oldest_pick = pending_picks.pop_front();
				if (position !== oldest_pick.position) begin
					$error("position: expected %0d, got %0d", oldest_pick.position, position);
					mismatches++;
				end
				if (last !== oldest_pick.last) begin
					$error("last: expected %0b, got %0b", oldest_pick.last, last);
					mismatches++;
				end
			end
		end
	end

	function automatic logic [fwes_pkg::BYTE_W-1:0] rand_byte();
		rand_byte = fwes_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic predict_byte(input logic [fwes_pkg::BYTE_W-1:0] b, input logic start);
		logic [fwes_pkg::CAND_W-1:0] mixed;
		int unsigned modulus;
		int unsigned cand;
		pick_t p;
		if (start) begin
			foreach (taken[i]) taken[i] = 1'b0;
			pick_count = '0;
			vec_done = 1'b0;
			prev_byte = b;
			prev_ok = 1'b1;
		end else if (vec_done) begin
			// finished vector: drop the byte
		end else if (!prev_ok) begin
			prev_byte = b;
			prev_ok = 1'b1;
		end else begin
			modulus = (len_reg == 0 || len_reg > DEPTH) ? DEPTH : len_reg;
			mixed = {prev_byte, 4'h0} ^ {4'h0, b};
			cand = mixed % modulus;
			prev_byte = b;
			// position zero never counts
			if (cand != 0 && !taken[cand]) begin
				taken[cand] = 1'b1;
				pick_count = pick_count + 1'b1;
				p.position = cand[fwes_pkg::CAND_W-1:0];
				p.last = (pick_count == weight_reg);
				if (p.last) vec_done = 1'b1;
				pending_picks.push_back(p);
			end
		end
	endtask

	task automatic offer_byte(input logic [fwes_pkg::BYTE_W-1:0] b, input logic start);
		int unsigned gap;
		in_valid <= 1'b1;
		seed_byte <= b;
		first <= start;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, start);
		bytes_sent++;
		if (!steady && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 20) : 1;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_vector(input int unsigned tail);
		offer_byte(rand_byte(), 1'b1);
		repeat (tail) offer_byte(rand_byte(), 1'b0);
	endtask

	// hold the sender until every position has come and the block has gone quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [fwes_pkg::LEN_W-1:0] len,
		input logic [fwes_pkg::WEIGHT_W-1:0] wt);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= fwes_pkg::REG_CODE_LENGTH;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		len_reg = len;
		cfg_index <= fwes_pkg::REG_ERROR_WEIGHT;
		cfg_data <= {{(fwes_pkg::LEN_W - fwes_pkg::WEIGHT_W){1'b0}}, wt};
		do @(posedge clk); while (!cfg_ready);
		weight_reg = wt;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		// reset acts as a start, so the first byte is only held
		offer_byte(8'h00, 1'b0);
		offer_byte(8'h00, 1'b0);
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'h5A, 1'b0);
		offer_byte(8'hFF, 1'b1);
		offer_byte(8'hFF, 1'b0);
		wait_idle();
	endtask

	task automatic test_length_extremes();
		set_config(13'd8191, 8'd3);
		offer_byte(8'h12, 1'b1);
		offer_byte(8'h34, 1'b0);
		offer_byte(8'h12, 1'b0);
		offer_byte(8'h34, 1'b0);
		offer_byte(8'hFF, 1'b0);
		offer_byte(8'h00, 1'b0);
		set_config(13'd0, 8'd2);
		offer_byte(8'hFF, 1'b1);
		offer_byte(8'h0F, 1'b0);
		offer_byte(8'h80, 1'b0);
		set_config(13'd1, 8'd1);
		offer_byte(8'h77, 1'b1);
		offer_byte(8'h13, 1'b0);
		offer_byte(8'hEE, 1'b0);
	endtask

	task automatic test_map_full();
		set_config(13'd2, 8'd4);
		offer_byte(8'h00, 1'b1);
		offer_byte(8'h01, 1'b0);
		offer_byte(8'h03, 1'b0);
		offer_byte(8'h05, 1'b0);
		offer_byte(8'hFE, 1'b0);
	endtask

	task automatic test_weight_wrap();
		// count wraps past 255 and meets a weight of zero
		set_config(13'd4096, 8'd0);
		run_vector(330);
	endtask

	task automatic test_backpressure();
		set_config(13'd4096, 8'd255);
		hold_seq <= hold_seq + 1;
		run_vector(40);
		wait_idle();
	endtask

	task automatic test_steady_stream();
		set_config(13'd300, 8'd12);
		steady <= 1'b1;
		repeat (4) run_vector($urandom_range(10, 20));
		wait_idle();
		steady <= 1'b0;
	endtask

	task automatic test_random_vectors();
		logic [fwes_pkg::LEN_W-1:0] len;
		logic [fwes_pkg::WEIGHT_W-1:0] wt;
		int unsigned phase_end;
		while (bytes_sent < ITEMS) begin
			case ($urandom_range(0, 7))
				0: len = 13'd2;
				1: len = 13'd4096;
				2: len = 13'd0;
				3: len = 13'd1;
				4: len = 13'd8191;
				5: len = fwes_pkg::LEN_W'($urandom_range(4097, 8191));
				6: len = fwes_pkg::LEN_W'($urandom_range(2, 64));
				default: len = fwes_pkg::LEN_W'($urandom_range(2, 4096));
			endcase
			case ($urandom_range(0, 5))
				0: wt = 8'd1;
				1: wt = 8'd255;
				2: wt = 8'd0;
				3: wt = fwes_pkg::WEIGHT_W'($urandom_range(1, 8));
				default: wt = fwes_pkg::WEIGHT_W'($urandom_range(1, 40));
			endcase
			set_config(len, wt);
			phase_end = bytes_sent + 100;
			while (bytes_sent < phase_end && bytes_sent < ITEMS) begin
				if ($urandom_range(0, 9) < 8)
					run_vector(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
						: $urandom_range(4, 40));
				else
					repeat ($urandom_range(1, 5))
						offer_byte(rand_byte(), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_length_extremes();
		test_map_full();
		test_weight_wrap();
		test_backpressure();
		test_steady_stream();
		test_random_vectors();
		wait_idle();
		if (mismatches == 0 && pending_picks.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hdl/fwes_pkg.sv
hdl/fwes_mod_unit.sv
hdl/fwes_map.sv
hdl/fixed_weight_error_sampler_core.sv
tb/tb_fixed_weight_error_sampler_core.sv
